/* rtl/triangle_quality_filter_core_defines.svh */
// ----------------------------------------------------------------------------
// Triangle quality filter assertion macros
// Concurrent assertion helpers used by the filter core.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_QUALITY_FILTER_CORE_DEFINES_SVH
`define TRIANGLE_QUALITY_FILTER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define TQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqf assertion failed");
// Next-cycle implication, checked outside reset.
`define TQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqf assertion failed");
`else
`define TQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tqf_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle quality filter package
// Widths, reset constants and the words passed between pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none
package tqf_pkg;
    // Coordinate width and quality width.
    localparam int COORD_BITS = 24;
    localparam int QW         = 24;
    localparam int CFG_W      = 24;
    localparam logic [CFG_W-1:0] CUT_RESET = 24'd196608;

    // Derived arithmetic widths.
    localparam int DW     = COORD_BITS + 1;   // corner difference
    localparam int PW     = 2 * DW;           // product of two differences
    localparam int XW     = PW + 1;           // cross product component
    localparam int MW     = PW;               // cross component magnitude
    localparam int HW     = MW / 2;           // half of a magnitude
    localparam int X2W    = 2 * MW + 2;       // squared cross norm
    localparam int RW     = X2W + 2;          // three times squared cross norm
    localparam int SW     = 2 * DW + 4;       // sum of squared edge lengths
    localparam int SHW    = SW / 2;           // half of the edge sum
    localparam int S2W    = 2 * SW;           // edge sum squared
    localparam int FRAC_SHIFT = 32;           // Q16 scale, squared
    localparam int LW     = S2W + FRAC_SHIFT; // right side of the test
    localparam int AW_RAW = 2 * QW + 2 + RW;
    localparam int AW     = ((AW_RAW > LW) ? AW_RAW : LW) + 1;

    // One triangle as three corners.
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] a;
        logic [2:0][COORD_BITS-1:0] b;
        logic [2:0][COORD_BITS-1:0] c;
    } t_tri;

    // Front section result handed to the root search.
    typedef struct packed {
        logic          valid;
        logic          degen;
        logic [RW-1:0] r;
        logic [LW-1:0] l;
    } t_root_in;

    // Root search result.
    typedef struct packed {
        logic          valid;
        logic          degen;
        logic [QW-1:0] q;
    } t_root_out;
endpackage
`default_nettype wire

/* rtl/tqf_in_if.sv */
// ----------------------------------------------------------------------------
// Triangle input channel
// Valid/ready channel carrying the three corners of one triangle.
// ----------------------------------------------------------------------------
`default_nettype none
interface tqf_in_if;
    logic valid;
    logic ready;
    logic [tqf_pkg::COORD_BITS-1:0] corner_a_x;
    logic [tqf_pkg::COORD_BITS-1:0] corner_a_y;
    logic [tqf_pkg::COORD_BITS-1:0] corner_a_z;
    logic [tqf_pkg::COORD_BITS-1:0] corner_b_x;
    logic [tqf_pkg::COORD_BITS-1:0] corner_b_y;
    logic [tqf_pkg::COORD_BITS-1:0] corner_b_z;
    logic [tqf_pkg::COORD_BITS-1:0] corner_c_x;
    logic [tqf_pkg::COORD_BITS-1:0] corner_c_y;
    logic [tqf_pkg::COORD_BITS-1:0] corner_c_z;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z,
        input  ready
    );
    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/tqf_out_if.sv */
// ----------------------------------------------------------------------------
// Quality result channel
// Valid/ready channel carrying the quality, keep and degenerate flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface tqf_out_if;
    logic valid;
    logic ready;
    logic [tqf_pkg::QW-1:0] quality;
    logic keep;
    logic degenerate;

    modport source (output valid, quality, keep, degenerate, input ready);
    modport sink (input valid, quality, keep, degenerate, output ready);
endinterface
`default_nettype wire

/* rtl/tqf_front.sv */
// ----------------------------------------------------------------------------
// Triangle quality front section
// Eight stages: edge vectors, cross product, squared norms and test operands.
// ----------------------------------------------------------------------------
`default_nettype none
module tqf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tqf_pkg::t_tri     i_tri,
    output tqf_pkg::t_root_in o_root
);
    import tqf_pkg::*;

    logic signed [DW-1:0] n1_p [3], n1_r [3], n1_e [3];
    logic signed [DW-1:0] r1_p [3], r1_r [3], r1_e [3];
    logic signed [PW-1:0] n2_x [6], r2_x [6];
    logic signed [PW-1:0] n2_q [9], r2_q [9];
    logic signed [XW-1:0] n3_c [3], r3_c [3];
    logic [SW-1:0]        n3_s [3], r3_s [3];
    logic [MW-1:0]        n4_m [3], r4_m [3];
    logic [SW-1:0]        n4_s, r4_s;
    logic                 n4_dg;
    logic [PW-1:0]        n5_hh [3], n5_hl [3], n5_ll [3];
    logic [PW-1:0]        r5_hh [3], r5_hl [3], r5_ll [3];
    logic [SW-1:0]        n5_shh, n5_shl, n5_sll, r5_shh, r5_shl, r5_sll;
    logic [X2W-1:0]       n6_sq [3], r6_sq [3];
    logic [S2W-1:0]       n6_s2, r6_s2;
    logic [X2W-1:0]       n7_x2, r7_x2;
    logic [LW-1:0]        n7_l, r7_l, r8_l;
    logic [RW-1:0]        n8_r, r8_r;
    logic [8:1]           r_v;
    logic [8:4]           r_dg;

    // Stage 1: edge vectors b-a, c-a and c-b.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_p[i] = DW'($signed(i_tri.b[i])) - DW'($signed(i_tri.a[i]));
            n1_r[i] = DW'($signed(i_tri.c[i])) - DW'($signed(i_tri.a[i]));
            n1_e[i] = DW'($signed(i_tri.c[i])) - DW'($signed(i_tri.b[i]));
        end
    end

    // Stage 2: cross product terms and squared edge components.
    always_comb begin
        n2_x[0] = r1_p[1] * r1_r[2];
        n2_x[1] = r1_p[2] * r1_r[1];
        n2_x[2] = r1_p[2] * r1_r[0];
        n2_x[3] = r1_p[0] * r1_r[2];
        n2_x[4] = r1_p[0] * r1_r[1];
        n2_x[5] = r1_p[1] * r1_r[0];
        for (int i = 0; i < 3; i++) begin
            n2_q[i]     = r1_p[i] * r1_p[i];
            n2_q[3 + i] = r1_r[i] * r1_r[i];
            n2_q[6 + i] = r1_e[i] * r1_e[i];
        end
    end

    // Stage 3: cross product components and squared edge lengths.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_c[i] = XW'(r2_x[2 * i]) - XW'(r2_x[2 * i + 1]);
            n3_s[i] = SW'($unsigned(r2_q[3 * i])) + SW'($unsigned(r2_q[3 * i + 1]))
                    + SW'($unsigned(r2_q[3 * i + 2]));
        end
    end

    // Stage 4: component magnitudes, edge sum and the degenerate check.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_m[i] = r3_c[i][XW-1] ? MW'(-r3_c[i]) : MW'(r3_c[i]);
        end
        n4_s  = r3_s[0] + r3_s[1] + r3_s[2];
        n4_dg = (r3_c[0] == '0) && (r3_c[1] == '0) && (r3_c[2] == '0);
    end

    // Stage 5: half-width partial products of the squares.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_hh[i] = r4_m[i][MW-1:HW] * r4_m[i][MW-1:HW];
            n5_hl[i] = r4_m[i][MW-1:HW] * r4_m[i][HW-1:0];
            n5_ll[i] = r4_m[i][HW-1:0] * r4_m[i][HW-1:0];
        end
        n5_shh = r4_s[SW-1:SHW] * r4_s[SW-1:SHW];
        n5_shl = r4_s[SW-1:SHW] * r4_s[SHW-1:0];
        n5_sll = r4_s[SHW-1:0] * r4_s[SHW-1:0];
    end

    // Stage 6: recombine the partial products.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_sq[i] = (X2W'(r5_hh[i]) << (2 * HW)) + (X2W'(r5_hl[i]) << (HW + 1))
                     + X2W'(r5_ll[i]);
        end
        n6_s2 = (S2W'(r5_shh) << (2 * SHW)) + (S2W'(r5_shl) << (SHW + 1)) + S2W'(r5_sll);
    end

    // Stage 7: squared cross norm and the scaled edge sum square.
    always_comb begin
        n7_x2 = r6_sq[0] + r6_sq[1] + r6_sq[2];
        n7_l  = LW'(r6_s2) << FRAC_SHIFT;
    end

    // Stage 8: three times the squared cross norm.
    assign n8_r = RW'(r7_x2) + (RW'(r7_x2) << 1);

    // Valid and degenerate flags travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    // Data registers of all stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= n1_p;
            r1_r   <= n1_r;
            r1_e   <= n1_e;
            r2_x   <= n2_x;
            r2_q   <= n2_q;
            r3_c   <= n3_c;
            r3_s   <= n3_s;
            r4_m   <= n4_m;
            r4_s   <= n4_s;
            r_dg   <= {r_dg[7:4], n4_dg};
            r5_hh  <= n5_hh;
            r5_hl  <= n5_hl;
            r5_ll  <= n5_ll;
            r5_shh <= n5_shh;
            r5_shl <= n5_shl;
            r5_sll <= n5_sll;
            r6_sq  <= n6_sq;
            r6_s2  <= n6_s2;
            r7_x2  <= n7_x2;
            r7_l   <= n7_l;
            r8_r   <= n8_r;
            r8_l   <= r7_l;
        end
    end

    assign o_root.valid = r_v[8];
    assign o_root.degen = r_dg[8];
    assign o_root.r     = r8_r;
    assign o_root.l     = r8_l;
endmodule
`default_nettype wire

/* rtl/tqf_root.sv */
// ----------------------------------------------------------------------------
// Triangle quality root search
// One stage per quality bit: the largest Q with 3*(2Q-1)^2*|X|^2 <= S^2*2^32.
// ----------------------------------------------------------------------------
`default_nettype none
module tqf_root (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tqf_pkg::t_root_in  i_root,
    output tqf_pkg::t_root_out o_res
);
    import tqf_pkg::*;

    // Stage inputs (index s) and stage registers (index s feeds s+1).
    logic [AW-1:0] w_a [QW+1], w_b [QW+1];
    logic [RW-1:0] w_r [QW+1];
    logic [LW-1:0] w_l [QW+1];
    logic [QW-1:0] w_q [QW+1];
    logic          w_dg [QW+1];
    logic [AW-1:0] n_a [QW], n_b [QW], r_a [QW], r_b [QW];
    logic [QW-1:0] n_q [QW], r_q [QW];
    logic [RW-1:0] r_r [QW];
    logic [LW-1:0] r_l [QW];
    logic          r_dg [QW];
    logic [QW-1:0] r_v;

    // Chain the stage registers; A = v^2*R and B = v*R start at zero.
    always_comb begin
        w_a[0]  = '0;
        w_b[0]  = '0;
        w_r[0]  = i_root.r;
        w_l[0]  = i_root.l;
        w_q[0]  = '0;
        w_dg[0] = i_root.degen;
        for (int s = 0; s < QW; s++) begin
            w_a[s + 1]  = r_a[s];
            w_b[s + 1]  = r_b[s];
            w_r[s + 1]  = r_r[s];
            w_l[s + 1]  = r_l[s];
            w_q[s + 1]  = r_q[s];
            w_dg[s + 1] = r_dg[s];
        end
    end

    // Each stage tries bit k: v grows by 2^(k+1) and (v-1)^2*R is tested.
    always_comb begin
        int k;
        logic [AW-1:0] cand_a, cand_b, test;
        logic take;
        k = 0;
        cand_a = '0;
        cand_b = '0;
        test = '0;
        take = 1'b0;
        for (int s = 0; s < QW; s++) begin
            k = QW - 1 - s;
            cand_a = w_a[s] + (w_b[s] << (k + 2)) + (AW'(w_r[s]) << (2 * k + 2));
            cand_b = w_b[s] + (AW'(w_r[s]) << (k + 1));
            test   = cand_a - (cand_b << 1) + AW'(w_r[s]);
            take   = (test <= AW'(w_l[s]));
            n_a[s] = take ? cand_a : w_a[s];
            n_b[s] = take ? cand_b : w_b[s];
            n_q[s] = w_q[s];
            n_q[s][k] = take;
        end
    end

    // Valid bits of the search stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_root.valid};
        end
    end

    // Data registers of the search stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_a[s]  <= n_a[s];
                r_b[s]  <= n_b[s];
                r_q[s]  <= n_q[s];
                r_r[s]  <= w_r[s];
                r_l[s]  <= w_l[s];
                r_dg[s] <= w_dg[s];
            end
        end
    end

    assign o_res.valid = r_v[QW-1];
    assign o_res.degen = w_dg[QW];
    assign o_res.q     = w_q[QW];
endmodule
`default_nettype wire

/* rtl/triangle_quality_filter_core.sv */
// ----------------------------------------------------------------------------
// Triangle quality filter core
// Inverse mean ratio quality of a triangle with a keep flag against a limit.
//
//   Channel   Direction  Word
//   i_in      sink       nine signed corner coordinates
//   o_out     source     quality Q8.16, keep, degenerate
//   i_cfg_*   write      cut-off ratio, Q8.16
//
// One triangle enters every cycle unless the output stalls; it passes
// 8 front stages, one search stage per quality bit (24) and the output register.
// Reset clears all valid bits and loads the cut-off with 3.0.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_quality_filter_core_defines.svh"
module triangle_quality_filter_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tqf_in_if.sink                  i_in,
    tqf_out_if.source               o_out,
    input  logic                    i_cfg_wr_en,
    input  logic [tqf_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import tqf_pkg::*;

    t_tri          w_tri;
    t_root_in      w_root;
    t_root_out     w_res;
    logic          en;
    logic [CFG_W-1:0] r_cut;
    logic          r_out_v;
    logic [QW-1:0] r_q, n_q;
    logic          r_keep, n_keep;
    logic          r_dg;

    // Gather the corners of the input word.
    assign w_tri.a[0] = i_in.corner_a_x;
    assign w_tri.a[1] = i_in.corner_a_y;
    assign w_tri.a[2] = i_in.corner_a_z;
    assign w_tri.b[0] = i_in.corner_b_x;
    assign w_tri.b[1] = i_in.corner_b_y;
    assign w_tri.b[2] = i_in.corner_b_z;
    assign w_tri.c[0] = i_in.corner_c_x;
    assign w_tri.c[1] = i_in.corner_c_y;
    assign w_tri.c[2] = i_in.corner_c_z;

    // The pipeline advances unless a finished word waits at the output.
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    tqf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_tri   (w_tri),
        .o_root  (w_root)
    );

    tqf_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_root  (w_root),
        .o_res   (w_res)
    );

    // Cut-off register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= CUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_cut <= i_cfg_wr_data;
        end
    end

    // Degenerate triangles report zero quality; keep compares with the limit.
    always_comb begin
        n_q    = w_res.degen ? '0 : w_res.q;
        n_keep = (n_q < r_cut);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q    <= n_q;
            r_keep <= n_keep;
            r_dg   <= w_res.degen;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.quality    = r_q;
    assign o_out.keep       = r_keep;
    assign o_out.degenerate = r_dg;

    `TQF_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_out.valid && o_out.degenerate, o_out.quality == '0)
    `TQF_ASSERT_IMP(a_keep_limit, i_clk, i_rst_n, o_out.valid, o_out.keep == (o_out.quality < r_cut))
    `TQF_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready)
    `TQF_ASSERT_NXT(a_out_load, i_clk, i_rst_n, w_res.valid && en, o_out.valid)
endmodule
`default_nettype wire
